/* rtl/core/swsr_pkg.sv */
package swsr_pkg;

   // Sequencer phase codes.
   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_START     = 3'd1;
   localparam logic [2:0] PH_RELEASE   = 3'd2;
   localparam logic [2:0] PH_RESP_LOW  = 3'd3;
   localparam logic [2:0] PH_RESP_HIGH = 3'd4;
   localparam logic [2:0] PH_BIT_LOW   = 3'd5;
   localparam logic [2:0] PH_BIT_HIGH  = 3'd6;
   localparam logic [2:0] PH_BIT_DELAY = 3'd7;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_LOW    = 2'd0;
   localparam logic [1:0] CSR_RELEASE      = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_DELAY = 2'd2;

   // Register reset values.
   localparam logic [15:0] START_LOW_RESET    = 16'd20000;
   localparam logic [7:0]  RELEASE_RESET      = 8'd5;
   localparam logic [7:0]  SAMPLE_DELAY_RESET = 8'd35;

   localparam int unsigned SHIFT_BITS = 32;
   localparam logic [15:0] SIGN_BIT   = 16'h8000;

   // Per-tick status seen by the result channel.
   typedef struct packed {
      logic drive_low;
      logic busy;
      logic done;
   } status_type;

   // Completed frame handed to the converter.
   typedef struct packed {
      logic                  load;
      logic [SHIFT_BITS-1:0] word;
   } frame_type;

endpackage

/* rtl/core/single_wire_sensor_reader_core.sv */
// Channel   Direction  Ports                         Payload
// req       in         req_tvalid/tready/tdata[7:0]  line_level, start_request
// rsp       out        rsp_tvalid/tready/tdata[39:0] drive_low, busy_res, frame_done,
//                                                    humidity_raw, temperature
// csr       in         csr_we/index/wdata            timing registers
//
// Each transaction is one microsecond tick; one tick enters per cycle while the result
// is not stalled, and it passes through the input register, then the result register.
// The sequencer state advances once per tick.
// Reset is synchronous and active high; it restores the register defaults.
// A stalled result holds the pipeline; the input register still takes one tick.
module single_wire_sensor_reader_core #(
   parameter int FRAME_BITS  = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: [0] line_level, [1] start_request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // tdata: [0] drive_low, [1] busy_res, [2] frame_done, [18:3] humidity_raw,
   // [34:19] temperature
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import swsr_pkg::*;

   localparam int EXT_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] ONE  = COUNT_WIDTH'(1);

   logic [15:0] start_low_ff;
   logic [7:0]  release_ff, delay_ff;

   logic        in_valid_ff;
   logic [1:0]  in_data_ff;
   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;
   logic        step_en;

   logic [EXT_WIDTH-1:0]   start_ext;
   logic [COUNT_WIDTH-1:0] start_clip, start_lim, release_lim, delay_lim;

   status_type         status;
   frame_type          frame;
   logic [15:0]        humidity_in;
   logic signed [15:0] temperature_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_low_ff <= START_LOW_RESET;
         release_ff   <= RELEASE_RESET;
         delay_ff     <= SAMPLE_DELAY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_LOW:    start_low_ff <= csr_wdata;
            CSR_RELEASE:      release_ff   <= csr_wdata[7:0];
            CSR_SAMPLE_DELAY: delay_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Limits clipped to the counter range; a zero hold or delay acts as one.
   assign start_ext   = EXT_WIDTH'(start_low_ff);
   assign start_clip  = (start_ext > EXT_WIDTH'(CMAX)) ? CMAX
                      : start_ext[COUNT_WIDTH-1:0];
   assign start_lim   = (start_clip == '0) ? ONE : start_clip;
   assign release_lim = COUNT_WIDTH'(release_ff);
   assign delay_lim   = (delay_ff == 8'd0) ? ONE : COUNT_WIDTH'(delay_ff);

   // A tick steps when the result register is free or being emptied.
   assign step_en    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata[1:0];
      end
   end

   swsr_seq #(
      .FRAME_BITS  (FRAME_BITS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .line_level    (in_data_ff[0]),
      .start_request (in_data_ff[1]),
      .start_lim     (start_lim),
      .release_lim   (release_lim),
      .delay_lim     (delay_lim),
      .status        (status),
      .frame         (frame)
   );

   swsr_conv u_conv (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .frame          (frame),
      .humidity_in    (humidity_in),
      .temperature_in (temperature_in)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= {5'd0, temperature_in, humidity_in,
                         status.done, status.busy, status.drive_low};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A completed reading always leaves the block idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[2] |-> !rsp_data_ff[1])
      else $error("frame done reported while busy");

   // Driving the wire low only happens during a reading.
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[0] |-> rsp_data_ff[1])
      else $error("wire driven low while not busy");

   // Input is refused only while a tick waits in the input register.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input refused without a stall");

   // A stepped tick always produces a result on the next cycle.
   a_step_rsp: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("stepped tick lost its result");

endmodule

/* rtl/core/swsr_seq.sv */
module swsr_seq #(
   parameter int FRAME_BITS  = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic                   line_level,
   input  logic                   start_request,
   input  logic [COUNT_WIDTH-1:0] start_lim,
   input  logic [COUNT_WIDTH-1:0] release_lim,
   input  logic [COUNT_WIDTH-1:0] delay_lim,
   output swsr_pkg::status_type   status,
   output swsr_pkg::frame_type    frame
);
   import swsr_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
   localparam logic [5:0] LAST_BIT = 6'(FRAME_BITS);

   logic [2:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] wait_ff, wait_in, wait_up;
   logic [5:0]             bits_ff, bits_in, bits_inc;
   logic [SHIFT_BITS-1:0]  shift_ff, shift_in, shift_next;
   logic                   done;

   // Saturating tick counter and the shifted frame with the sampled bit.
   assign wait_up    = (wait_ff < CMAX) ? wait_ff + 1'b1 : wait_ff;
   assign bits_inc   = bits_ff + 6'd1;
   assign shift_next = {shift_ff[SHIFT_BITS-2:0], line_level};

   // One tick of the protocol sequencer.
   always_comb begin
      phase_in = phase_ff;
      wait_in  = wait_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      done     = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start_request) begin
               phase_in = PH_START;
               wait_in  = '0;
               bits_in  = '0;
               shift_in = '0;
            end
         end
         PH_START: begin
            wait_in = wait_up;
            if (wait_up >= start_lim) begin
               phase_in = PH_RELEASE;
               wait_in  = '0;
            end
         end
         PH_RELEASE: begin
            // The first watched tick already checks for the low response.
            if (wait_ff >= release_lim) begin
               phase_in = line_level ? PH_RESP_LOW : PH_RESP_HIGH;
            end else begin
               wait_in = wait_up;
            end
         end
         PH_RESP_LOW: begin
            if (!line_level) phase_in = PH_RESP_HIGH;
         end
         PH_RESP_HIGH: begin
            if (line_level) phase_in = PH_BIT_LOW;
         end
         PH_BIT_LOW: begin
            if (!line_level) phase_in = PH_BIT_HIGH;
         end
         PH_BIT_HIGH: begin
            if (line_level) begin
               phase_in = PH_BIT_DELAY;
               wait_in  = '0;
            end
         end
         PH_BIT_DELAY: begin
            wait_in = wait_up;
            if (wait_up >= delay_lim) begin
               shift_in = shift_next;
               bits_in  = bits_inc;
               if (bits_inc >= LAST_BIT) begin
                  phase_in = PH_IDLE;
                  wait_in  = '0;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_BIT_LOW;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wait_ff  <= '0;
         bits_ff  <= '0;
         shift_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
      end
   end

   assign status.drive_low = (phase_in == PH_START);
   assign status.busy      = (phase_in != PH_IDLE);
   assign status.done      = done;
   assign frame.load       = done;
   assign frame.word       = shift_in;

endmodule

/* rtl/core/swsr_conv.sv */
module swsr_conv (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  swsr_pkg::frame_type frame,
   output logic [15:0]         humidity_in,
   output logic signed [15:0]  temperature_in
);
   import swsr_pkg::*;

   logic [15:0]        humidity_ff;
   logic signed [15:0] temperature_ff;
   logic [15:0]        temp_word, temp_twos;

   // Sign-magnitude to two's complement; negative zero folds to zero.
   assign temp_word = frame.word[15:0];
   assign temp_twos = (temp_word & SIGN_BIT) == 16'd0 ? temp_word
                    : 16'd0 - {1'b0, temp_word[14:0]};

   // Next hold values, seen by the result register on the same edge.
   assign humidity_in    = frame.load ? frame.word[31:16] : humidity_ff;
   assign temperature_in = frame.load ? $signed(temp_twos) : temperature_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         humidity_ff    <= '0;
         temperature_ff <= '0;
      end else if (step_en) begin
         humidity_ff    <= humidity_in;
         temperature_ff <= temperature_in;
      end
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import swsr_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int RANDOM_TICKS = 500;
   localparam int DRAIN_CYCLES = 8;
   localparam int FRAME_LENGTH = 32;
   localparam int PRINT_LIMIT = 100;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // Field layout of the result transaction, lowest bit last.
   typedef struct packed {
      logic [15:0] temperature;
      logic [15:0] humidity;
      logic        frame_done;
      logic        busy;
      logic        drive_low;
   } tick_result_type;

   // One directed tick; typed rows carry their expected status inline.
   typedef struct packed {
      bit   typed;
      logic line;
      logic start;
      logic drive_low;
      logic busy;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // tdata: [0] line_level, [1] start_request
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // tdata: [0] drive_low, [1] busy_res, [2] frame_done, [18:3] humidity_raw,
   // [34:19] temperature
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_START_LOW;
   logic [15:0] csr_wdata = '0;

   single_wire_sensor_reader_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Timing registers as the reader sees them.
   logic [15:0] cfg_start_low = START_LOW_RESET;
   logic [7:0]  cfg_release = RELEASE_RESET;
   logic [7:0]  cfg_sample = SAMPLE_DELAY_RESET;

   // Reader state tracked tick by tick.
   logic [2:0]  rd_phase = PH_IDLE;
   logic [15:0] rd_wait = '0;
   logic [5:0]  rd_bits = '0;
   logic [31:0] rd_shift = '0;
   logic [15:0] humidity_hold = '0;
   logic [15:0] temperature_hold = '0;

   tick_result_type tick_results_due[$];
   logic            wire_script[$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int ticks_accepted = 0;
   int readings_left = 0;
   bit tx_quiet = 1'b0;

   directed_row_type directed_rows [7] = '{
      5'b11000, 5'b10000, 5'b10111, 5'b11111, 5'b11011, 5'b00100, 5'b01000
   };

   // Advance the reader by one tick and return the status it reports.
   function automatic tick_result_type advance_reader(input logic line, input logic start);
      tick_result_type r;
      logic [15:0]     lim;
      r = '0;
      case (rd_phase)
         PH_IDLE: begin
            if (start) begin
               rd_phase = PH_START;
               rd_wait = '0;
               rd_bits = '0;
               rd_shift = '0;
            end
         end
         PH_START: begin
            if (rd_wait != COUNT_MAX) rd_wait = rd_wait + 16'd1;
            lim = (cfg_start_low == 16'd0) ? 16'd1 : cfg_start_low;
            if (rd_wait >= lim) begin
               rd_phase = PH_RELEASE;
               rd_wait = '0;
            end
         end
         PH_RELEASE: begin
            // The tick after the ignored stretch already looks at the wire.
            if (rd_wait >= {8'd0, cfg_release}) begin
               rd_phase = line ? PH_RESP_LOW : PH_RESP_HIGH;
            end else if (rd_wait != COUNT_MAX) begin
               rd_wait = rd_wait + 16'd1;
            end
         end
         PH_RESP_LOW: if (!line) rd_phase = PH_RESP_HIGH;
         PH_RESP_HIGH: if (line) rd_phase = PH_BIT_LOW;
         PH_BIT_LOW: if (!line) rd_phase = PH_BIT_HIGH;
         PH_BIT_HIGH: begin
            if (line) begin
               rd_phase = PH_BIT_DELAY;
               rd_wait = '0;
            end
         end
         default: begin
            if (rd_wait != COUNT_MAX) rd_wait = rd_wait + 16'd1;
            lim = (cfg_sample == 8'd0) ? 16'd1 : {8'd0, cfg_sample};
            if (rd_wait >= lim) begin
               rd_shift = {rd_shift[30:0], line};
               rd_bits = rd_bits + 6'd1;
               if (rd_bits >= 6'(FRAME_LENGTH)) begin
                  // Sign-magnitude to two's complement; negative zero folds to zero.
                  humidity_hold = rd_shift[31:16];
                  temperature_hold = rd_shift[15] ? 16'd0 - {1'b0, rd_shift[14:0]}
                                                  : rd_shift[15:0];
                  rd_phase = PH_IDLE;
                  rd_wait = '0;
                  r.frame_done = 1'b1;
               end else begin
                  rd_phase = PH_BIT_LOW;
               end
            end
         end
      endcase
      r.drive_low = (rd_phase == PH_START);
      r.busy = (rd_phase != PH_IDLE);
      r.humidity = humidity_hold;
      r.temperature = temperature_hold;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Queue the wire levels of one sensor answer, starting at the first watched tick.
   task automatic build_frame_script();
      logic [31:0] word;
      int          lim;
      int          low_len;
      int          high_len;
      int          prev_high;
      int          cut;
      bit          prev_zero;
      lim = (cfg_sample == 8'd0) ? 1 : int'(cfg_sample);
      case ($urandom_range(11, 0))
         0: word = 32'h0000_8000;
         1: word = 32'hFFFF_FFFF;
         2: word = 32'h0000_0000;
         3: word = 32'h0000_7FFF;
         4: word = 32'hFFFF_0001;
         5: word = 32'h1234_FFFF;
         default: word = $urandom;
      endcase
      // Sensor response: optional idle high, then low, then high.
      repeat ($urandom_range(2, 0)) wire_script.push_back(1'b1);
      repeat ($urandom_range(5, 1)) wire_script.push_back(1'b0);
      repeat ($urandom_range(5, 1)) wire_script.push_back(1'b1);
      // Each bit is a low gap then a high pulse; a long pulse reads as one.
      // After a short pulse the low must cover the sample tick and the tick after.
      prev_zero = 1'b0;
      prev_high = 0;
      for (int i = FRAME_LENGTH - 1; i >= -1; i--) begin
         low_len = $urandom_range(4, 1);
         if (prev_zero && low_len < lim + 2 - prev_high) low_len = lim + 2 - prev_high;
         repeat (low_len) wire_script.push_back(1'b0);
         if (i >= 0) begin
            high_len = word[i] ? lim + $urandom_range(4, 1) : $urandom_range(lim, 1);
            repeat (high_len) wire_script.push_back(1'b1);
            prev_zero = !word[i];
            prev_high = high_len;
         end
      end
      // Now and then the answer is cut short, garbled or glitched.
      if ($urandom_range(7, 0) == 0) begin
         cut = $urandom_range(wire_script.size() - 1, 0);
         case ($urandom_range(2, 0))
            0: while (wire_script.size() > cut) void'(wire_script.pop_back());
            1: for (int k = cut; k < cut + 5 && k < wire_script.size(); k++) begin
               wire_script[k] = !wire_script[k];
            end
            default: repeat ($urandom_range(6, 1)) begin
               wire_script.insert(cut, $urandom_range(1, 0) != 0);
            end
         endcase
      end
   endtask

   // Choose the next tick from where the reader will be when it sees it.
   task automatic pick_next(output logic line, output logic start);
      start = 1'b0;
      line = 1'b1;
      if (rd_phase == PH_IDLE) begin
         wire_script.delete();
         line = ($urandom_range(7, 0) != 0);
         if (readings_left > 0 && $urandom_range(2, 0) == 0) begin
            start = 1'b1;
            readings_left--;
            build_frame_script();
         end
      end else begin
         // Start requests while busy must be ignored.
         start = ($urandom_range(7, 0) == 0);
         if (rd_phase == PH_START) begin
            line = ($urandom_range(7, 0) == 0);
         end else if (rd_phase == PH_RELEASE && rd_wait < {8'd0, cfg_release}) begin
            line = ($urandom_range(7, 0) != 0);
         end else if (wire_script.size() != 0) begin
            line = wire_script.pop_front();
         end else begin
            // Noise walks a lost reader back to idle.
            line = ($urandom_range(1, 0) != 0);
         end
      end
   endtask

   // Offer one tick, wait for the transaction, and record its expected status.
   task automatic send_tick(input logic line, input logic start, input bit typed,
                            input logic drive_w, input logic busy_w);
      tick_result_type predicted;
      int              gap;
      if ($urandom_range(499, 0) == 0) tx_quiet = !tx_quiet;
      if (!tx_quiet && $urandom_range(5, 0) == 0) begin
         gap = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {6'd0, start, line};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_reader(line, start);
      if (typed) begin
         predicted = '0;
         predicted.drive_low = drive_w;
         predicted.busy = busy_w;
      end
      tick_results_due.push_back(predicted);
      ticks_accepted++;
   endtask

   // Write the timing registers once the pipeline has drained.
   task automatic program_timing(input logic [15:0] start_low, input logic [7:0] release_len,
                                 input logic [7:0] sample_len);
      req_tvalid <= 1'b0;
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_START_LOW;
      csr_wdata <= start_low;
      @(posedge clock);
      cfg_start_low = start_low;
      // Upper data bits of the byte-wide registers are don't-care.
      csr_index <= CSR_RELEASE;
      csr_wdata <= {8'($urandom), release_len};
      @(posedge clock);
      cfg_release = release_len;
      csr_index <= CSR_SAMPLE_DELAY;
      csr_wdata <= {8'($urandom), sample_len};
      @(posedge clock);
      cfg_sample = sample_len;
      csr_we <= 1'b0;
   endtask

   task automatic run_readings(input int count);
      logic line;
      logic start;
      readings_left = count;
      while (readings_left != 0 || rd_phase != PH_IDLE) begin
         pick_next(line, start);
         send_tick(line, start, 1'b0, 1'b0, 1'b0);
      end
   endtask

   // Result side: compare each transaction, then pace tready.
   int stall_left = 0;
   int hold_left = 0;
   bit pressure_done = 1'b0;
   bit rx_quiet = 1'b0;

   always @(posedge clock) begin : result_check
      tick_result_type got;
      tick_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[34:0];
            if (tick_results_due.size() == 0) begin
               report_mismatch("result with no expected tick pending");
            end else begin
               want = tick_results_due.pop_front();
               if (got.drive_low !== want.drive_low)
                  report_mismatch($sformatf("drive_low %0b, expected %0b",
                                            got.drive_low, want.drive_low));
               if (got.busy !== want.busy)
                  report_mismatch($sformatf("busy_res %0b, expected %0b", got.busy, want.busy));
               if (got.frame_done !== want.frame_done)
                  report_mismatch($sformatf("frame_done %0b, expected %0b",
                                            got.frame_done, want.frame_done));
               if (got.humidity !== want.humidity)
                  report_mismatch($sformatf("humidity_raw %h, expected %h",
                                            got.humidity, want.humidity));
               if (got.temperature !== want.temperature)
                  report_mismatch($sformatf("temperature %h, expected %h",
                                            got.temperature, want.temperature));
               if (rsp_tdata[39:35] !== 5'd0)
                  report_mismatch($sformatf("padding bits %b", rsp_tdata[39:35]));
            end
         end

         // One long hold-off lets the block fill up and stall its input.
         if ($urandom_range(499, 0) == 0) rx_quiet = !rx_quiet;
         if (!pressure_done && ticks_accepted >= 1000) begin
            hold_left = 400;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!rx_quiet && $urandom_range(5, 0) == 0) begin
            stall_left = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(3, 1);
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [15:0] start_low;
      logic [7:0]  release_len;
      logic [7:0]  sample_len;
      int          ticks_at_start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks at reset timing: idle, start, start while busy.
      foreach (directed_rows[i]) begin
         send_tick(directed_rows[i].line, directed_rows[i].start, directed_rows[i].typed,
                   directed_rows[i].drive_low, directed_rows[i].busy);
      end

      // Shorten the timing mid-reading, then let the sensor answer it.
      program_timing(16'd1, 8'd0, 8'd1);
      if (rd_phase != PH_IDLE) build_frame_script();
      run_readings(0);

      // Shortest timing, zero timing (start and sample delay treated as one), and the longest release.
      run_readings(2);
      program_timing(16'd0, 8'd0, 8'd0);
      run_readings(2);
      program_timing(16'd3, 8'hFF, 8'd2);
      run_readings(1);

      // Random timing settings, mostly short so that many frames complete.
      ticks_at_start = ticks_accepted;
      while (ticks_accepted - ticks_at_start < RANDOM_TICKS) begin
         start_low = ($urandom_range(9, 0) == 0) ? 16'd0 : 16'($urandom_range(12, 1));
         release_len = ($urandom_range(9, 0) == 0) ? 8'hFF : 8'($urandom_range(6, 0));
         sample_len = ($urandom_range(9, 0) == 0) ? 8'($urandom_range(40, 20))
                                                  : 8'($urandom_range(6, 0));
         program_timing(start_low, release_len, sample_len);
         run_readings($urandom_range(3, 1));
      end

      req_tvalid <= 1'b0;
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
